// File: hdl/clin_pkg.sv
// ----------------------------------------------------------------------------
// clin_pkg: shared types and constants for the clamped linear interpolator
// Command/status bundles between controller and datapath, region and
// request function codes.
// ----------------------------------------------------------------------------
package clin_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH     = 8;
   localparam int CSR_WIDTH       = 9;
   localparam int MUL_CHUNK       = 16;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] REGION_INSIDE = 2'd0;
   localparam logic [1:0] REGION_FIRST  = 2'd1;
   localparam logic [1:0] REGION_LAST   = 2'd2;

   typedef struct packed {
      logic ram_wr;
      logic q_load;
      logic srch_rd;
      logic srch_upd;
      logic pick_rd;
      logic hi_rd;
      logic diff_ld;
      logic mul_step;
      logic div_step;
      logic out_clamp;
      logic out_interp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic first_zero;
      logic first_over;
   } status_type;

endpackage

// File: hdl/clin_ram.sv
// ----------------------------------------------------------------------------
// clin_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module clin_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/clin_ctrl.sv
// ----------------------------------------------------------------------------
// clin_ctrl: sequencer for the clamped linear interpolator
// Steps the binary search, knot fetch, chunked multiply and restoring divide.
// ----------------------------------------------------------------------------
module clin_ctrl #(
   parameter int VALUE_WIDTH = clin_pkg::DEF_VALUE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 func,
   output logic                 busy,
   input  clin_pkg::status_type status,
   output clin_pkg::cmd_type    cmd
);

   localparam int NCH  = (VALUE_WIDTH + clin_pkg::MUL_CHUNK - 1) / clin_pkg::MUL_CHUNK;
   localparam int CNTW = $clog2(VALUE_WIDTH + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_RD  = 4'd1;
   localparam logic [3:0] S_SRCH_CMP = 4'd2;
   localparam logic [3:0] S_PICK     = 4'd3;
   localparam logic [3:0] S_CLAMP    = 4'd4;
   localparam logic [3:0] S_FETCH_HI = 4'd5;
   localparam logic [3:0] S_DIFF     = 4'd6;
   localparam logic [3:0] S_MUL      = 4'd7;
   localparam logic [3:0] S_DIV      = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (func == clin_pkg::FUNC_QUERY) begin
                  cmd.q_load = 1'b1;
                  state_in   = S_SRCH_RD;
               end else begin
                  cmd.ram_wr = 1'b1;
               end
            end
         end
         S_SRCH_RD: begin
            if (status.count_zero) begin
               state_in = S_PICK;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_upd = 1'b1;
            state_in     = S_SRCH_RD;
         end
         S_PICK: begin
            cmd.pick_rd = 1'b1;
            if (status.first_zero || status.first_over) begin
               state_in = S_CLAMP;
            end else begin
               state_in = S_FETCH_HI;
            end
         end
         S_CLAMP: begin
            cmd.out_clamp = 1'b1;
            state_in      = S_IDLE;
         end
         S_FETCH_HI: begin
            cmd.hi_rd = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_ld = 1'b1;
            cnt_in      = CNTW'(NCH - 1);
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNTW'(VALUE_WIDTH - 1);
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FINISH: begin
            cmd.out_interp = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_div_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> (state_ff == S_FINISH))
      else $error("divide did not end after last step");

   a_out_frees: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_clamp || cmd.out_interp) |=> !busy)
      else $error("busy still high after result");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (cnt_ff <= CNTW'(NCH - 1)))
      else $error("multiply chunk count out of range");

endmodule

// File: hdl/clin_dp.sv
// ----------------------------------------------------------------------------
// clin_dp: datapath for the clamped linear interpolator
// Knot tables, search registers, chunked multiplier, restoring divider.
// ----------------------------------------------------------------------------
module clin_dp #(
   parameter int TABLE_DEPTH = clin_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = clin_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  clin_pkg::cmd_type               cmd,
   output clin_pkg::status_type            status,
   input  logic [clin_pkg::INDEX_WIDTH-1:0] entry_index,
   input  logic [VALUE_WIDTH-1:0]          entry_x,
   input  logic [VALUE_WIDTH-1:0]          entry_y,
   input  logic [VALUE_WIDTH-1:0]          query_x,
   input  logic                            csr_wr_en,
   input  logic [clin_pkg::CSR_WIDTH-1:0]  csr_wr_data,
   output logic                            rsp_strobe,
   output logic [VALUE_WIDTH-1:0]          rsp_result_y,
   output logic [1:0]                      rsp_region
);

   localparam int W    = VALUE_WIDTH;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CH   = clin_pkg::MUL_CHUNK;
   localparam int NCH  = (W + CH - 1) / CH;
   localparam int PW   = NCH * CH;
   localparam int PPW  = W + CH;
   localparam int ACCW = 2 * W;
   localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W - 1){1'b0}}};

   logic [clin_pkg::CSR_WIDTH-1:0] point_count_ff;
   logic [CW-1:0]   n_ff, first_ff, count_ff;
   logic [CW-1:0]   n_in, half, mid, pick_idx;
   logic [W-1:0]    q_ff, x0_ff, y0_ff, dx_ff, dy_ff;
   logic            rising_ff;
   logic [1:0]      region_ff;
   logic [PW-1:0]   dq_ff;
   logic [ACCW-1:0] acc_ff;
   logic [AW-1:0]   rd_addr;
   logic [W-1:0]    x_data, y_data, x_b, y_b;
   logic            ram_we;
   logic [PPW-1:0]  pp;
   logic [W:0]      rem_sh, rem_diff;
   logic [W-1:0]    step, uy;
   logic            rsp_strobe_ff;
   logic [W-1:0]    rsp_result_ff;
   logic [1:0]      rsp_region_ff;

   // table storage
   assign ram_we = cmd.ram_wr && (32'(entry_index) < 32'(TABLE_DEPTH));

   always_comb begin
      if (cmd.srch_rd) begin
         rd_addr = mid[AW-1:0];
      end else if (cmd.pick_rd) begin
         rd_addr = pick_idx[AW-1:0];
      end else begin
         rd_addr = first_ff[AW-1:0];
      end
   end

   clin_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(entry_index)),
      .wr_data (entry_x),
      .rd_addr (rd_addr),
      .rd_data (x_data)
   );

   clin_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(entry_index)),
      .wr_data (entry_y),
      .rd_addr (rd_addr),
      .rd_data (y_data)
   );

   // offset binary keeps signed order under unsigned compare
   assign x_b = x_data ^ SIGN_BIT;
   assign y_b = y_data ^ SIGN_BIT;

   always_comb begin
      if (point_count_ff == '0) begin
         n_in = CW'(1);
      end else if (32'(point_count_ff) > 32'(TABLE_DEPTH)) begin
         n_in = CW'(TABLE_DEPTH);
      end else begin
         n_in = CW'(point_count_ff);
      end
   end

   assign half = count_ff >> 1;
   assign mid  = first_ff + half;

   always_comb begin
      if (first_ff == '0) begin
         pick_idx = '0;
      end else if (first_ff >= n_ff) begin
         pick_idx = n_ff - 1'b1;
      end else begin
         pick_idx = first_ff - 1'b1;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.first_zero = (first_ff == '0);
   assign status.first_over = (first_ff >= n_ff);

   // arithmetic
   assign pp       = PPW'(dy_ff) * PPW'(dq_ff[PW-1 -: CH]);
   assign rem_sh   = {acc_ff[ACCW-1:W], acc_ff[W-1]};
   assign rem_diff = rem_sh - {1'b0, dx_ff};
   assign step     = acc_ff[W-1:0];
   assign uy       = rising_ff ? (y0_ff + step) : (y0_ff - step);

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= clin_pkg::CSR_WIDTH'(1);
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         q_ff     <= query_x ^ SIGN_BIT;
         n_ff     <= n_in;
         first_ff <= '0;
         count_ff <= n_in;
      end
      if (cmd.srch_upd) begin
         if (x_b < q_ff) begin
            first_ff <= mid + 1'b1;
            count_ff <= count_ff - half - 1'b1;
         end else begin
            count_ff <= half;
         end
      end
      if (cmd.pick_rd) begin
         if (first_ff == '0) begin
            region_ff <= clin_pkg::REGION_FIRST;
         end else if (first_ff >= n_ff) begin
            region_ff <= clin_pkg::REGION_LAST;
         end else begin
            region_ff <= clin_pkg::REGION_INSIDE;
         end
      end
      if (cmd.hi_rd) begin
         x0_ff <= x_b;
         y0_ff <= y_b;
      end
      if (cmd.diff_ld) begin
         dx_ff     <= x_b - x0_ff;
         dq_ff     <= PW'(q_ff - x0_ff);
         rising_ff <= (y_b >= y0_ff);
         dy_ff     <= (y_b >= y0_ff) ? (y_b - y0_ff) : (y0_ff - y_b);
         acc_ff    <= '0;
      end
      if (cmd.mul_step) begin
         acc_ff <= (acc_ff << CH) + ACCW'(pp);
         dq_ff  <= dq_ff << CH;
      end
      if (cmd.div_step) begin
         if (!rem_diff[W]) begin
            acc_ff <= {rem_diff[W-1:0], acc_ff[W-2:0], 1'b1};
         end else begin
            acc_ff <= {rem_sh[W-1:0], acc_ff[W-2:0], 1'b0};
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.out_clamp || cmd.out_interp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_clamp) begin
         rsp_result_ff <= y_data;
         rsp_region_ff <= region_ff;
      end else if (cmd.out_interp) begin
         rsp_result_ff <= uy ^ SIGN_BIT;
         rsp_region_ff <= region_ff;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_result_y = rsp_result_ff;
   assign rsp_region   = rsp_region_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_rd |-> (first_ff < n_ff))
      else $error("search probe beyond valid knots");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (acc_ff[ACCW-1:W] < dx_ff))
      else $error("partial remainder not below divisor");

   a_interp_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.out_interp |-> (first_ff != '0 && first_ff < n_ff))
      else $error("interpolation outside the knot range");

endmodule

// File: hdl/clamped_linear_interpolator.sv
// ----------------------------------------------------------------------------
// clamped_linear_interpolator: piecewise linear lookup with end clamping
// A knot load is written while idle and gives no result. A query runs s search steps
// (s <= ceil(log2(n+1))), each a read and a compare, then strobes a clamped result, or
// an interpolated one after a chunked multiply and a divide, one divide bit a cycle.
// Throughput: one request at a time; busy falls as the result strobes and the
// receiver cannot stall. Reset idles the block, sets point_count to 1, keeps tables.
// ----------------------------------------------------------------------------
module clamped_linear_interpolator #(
   parameter int TABLE_DEPTH = clin_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = clin_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [clin_pkg::INDEX_WIDTH-1:0] req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]    req_entry_x,
   input  logic signed [VALUE_WIDTH-1:0]    req_entry_y,
   input  logic signed [VALUE_WIDTH-1:0]    req_query_x,
   output logic                             rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0]    rsp_result_y,
   output logic [1:0]                       rsp_region,
   input  logic                             csr_wr_en,
   input  logic [clin_pkg::CSR_WIDTH-1:0]   csr_wr_data
);

   clin_pkg::cmd_type    cmd;
   clin_pkg::status_type status;
   logic [VALUE_WIDTH-1:0] result_y;

   clin_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_func),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   clin_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .entry_index  (req_entry_index),
      .entry_x      (req_entry_x),
      .entry_y      (req_entry_y),
      .query_x      (req_query_x),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_result_y (result_y),
      .rsp_region   (rsp_region)
   );

   assign rsp_result_y = result_y;

endmodule

// File: test/clamped_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// clamped_linear_interpolator_tb: self-checking bench for the interpolator
// Loads knot tables through the request port and changes point_count between
// phases, then sends queries below, on, between and above the knots. Sorted
// and unsorted tables, zero and oversized counts are covered. A scoreboard
// predicts every query result and checks each strobed result in order.
// ----------------------------------------------------------------------------
module clamped_linear_interpolator_tb;

   localparam int DEPTH          = clin_pkg::DEF_TABLE_DEPTH;
   localparam int ITEM_TARGET    = 1750;
   localparam int SETTLE_CYCLES  = 70;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   typedef logic [clin_pkg::DEF_VALUE_WIDTH-1:0]   value_type;
   typedef logic [2*clin_pkg::DEF_VALUE_WIDTH-1:0] wide_type;
   typedef logic [clin_pkg::INDEX_WIDTH-1:0]       index_type;
   typedef logic [clin_pkg::CSR_WIDTH-1:0]         count_type;

   localparam value_type SIGN_BIT = value_type'(1) << (clin_pkg::DEF_VALUE_WIDTH - 1);

   typedef struct packed {
      value_type  result_y;
      logic [1:0] region;
   } interp_result_type;

   class interp_scoreboard;
      value_type         knot_x[DEPTH];
      value_type         knot_y[DEPTH];
      count_type         point_count;
      interp_result_type expected_q[$];
      int                errors;
      int                loads;
      int                queries;
      int                settings;
      int                region_hits[3];

      function new();
         point_count = 1;
         errors = 0;
         loads = 0;
         queries = 0;
         settings = 0;
         foreach (region_hits[i]) region_hits[i] = 0;
      endfunction

      function int active_count();
         if (point_count == 0) return 1;
         if (point_count > DEPTH) return DEPTH;
         return int'(point_count);
      endfunction

      // binary search on offset-binary keys, then clamp or interpolate
      function interp_result_type interpolate(value_type qx);
         int                n;
         int                lo;
         int                cnt;
         int                half;
         value_type         q;
         value_type         x0;
         value_type         x1;
         value_type         y0;
         value_type         y1;
         value_type         dy;
         value_type         uy;
         wide_type          prod;
         wide_type          stp;
         logic              rising;
         interp_result_type r;
         n = active_count();
         q = qx ^ SIGN_BIT;
         lo = 0;
         cnt = n;
         while (cnt > 0) begin
            half = cnt / 2;
            if ((knot_x[lo + half] ^ SIGN_BIT) < q) begin
               lo = lo + half + 1;
               cnt = cnt - half - 1;
            end else begin
               cnt = half;
            end
         end
         if (lo == 0) begin
            r.result_y = knot_y[0];
            r.region = clin_pkg::REGION_FIRST;
         end else if (lo >= n) begin
            r.result_y = knot_y[n - 1];
            r.region = clin_pkg::REGION_LAST;
         end else begin
            x0 = knot_x[lo - 1] ^ SIGN_BIT;
            x1 = knot_x[lo] ^ SIGN_BIT;
            y0 = knot_y[lo - 1] ^ SIGN_BIT;
            y1 = knot_y[lo] ^ SIGN_BIT;
            rising = (y1 >= y0);
            dy = rising ? y1 - y0 : y0 - y1;
            prod = wide_type'(dy) * wide_type'(value_type'(q - x0));
            stp = prod / wide_type'(value_type'(x1 - x0));
            uy = rising ? y0 + value_type'(stp) : y0 - value_type'(stp);
            r.result_y = uy ^ SIGN_BIT;
            r.region = clin_pkg::REGION_INSIDE;
         end
         return r;
      endfunction

      function void note_request(logic func, index_type idx, value_type ex, value_type ey,
                                 value_type qx);
         if (func == clin_pkg::FUNC_LOAD) begin
            knot_x[idx] = ex;
            knot_y[idx] = ey;
            loads++;
         end else begin
            expected_q = {expected_q, interpolate(qx)};
            queries++;
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(value_type y, logic [1:0] region);
         interp_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result y=%h region=%0d", y, region));
         end else begin
            want = expected_q.pop_front();
            region_hits[want.region]++;
            if (y !== want.result_y)
               report($sformatf("result_y %h, expected %h", y, want.result_y));
            if (region !== want.region)
               report($sformatf("region %0d, expected %0d", region, want.region));
         end
      endtask
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_func = clin_pkg::FUNC_LOAD;
   index_type req_entry_index = '0;
   value_type req_entry_x = '0;
   value_type req_entry_y = '0;
   value_type req_query_x = '0;
   logic      rsp_strobe;
   value_type rsp_result_y;
   logic [1:0] rsp_region;
   logic      csr_wr_en = 1'b0;
   count_type csr_wr_data = '0;

   interp_scoreboard sb = new();
   bit idle_on = 1'b0;
   int items = 0;

   clamped_linear_interpolator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_y    (rsp_result_y),
      .rsp_region      (rsp_region),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result(rsp_result_y, rsp_region);
   end

   task automatic send_request(logic func, index_type idx, value_type ex, value_type ey,
                               value_type qx);
      int gap;
      gap = idle_on ? $urandom_range(5, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_entry_index <= idx;
      req_entry_x <= ex;
      req_entry_y <= ey;
      req_query_x <= qx;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(func, idx, ex, ey, qx);
      items++;
   endtask

   // hold off until every pending result is in and the block is quiet
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_point_count(count_type value);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.point_count = value;
      sb.settings++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_table(int n, bit sorted);
      longint unsigned u;
      longint unsigned gmax;
      longint unsigned room;
      value_type       x;
      value_type       y;
      case ($urandom_range(3, 0))
         0: gmax = 0;
         1: gmax = 15;
         2: gmax = 65535;
         default: gmax = 64'hFFFF_FFFF / n - 1;
      endcase
      room = 64'hFFFF_FFFF - longint'(n - 1) * (gmax + 1);
      u = $urandom_range(32'(room), 0);
      y = $urandom;
      for (int i = 0; i < n; i++) begin
         if (i > 0) u = u + 1 + $urandom_range(32'(gmax), 0);
         x = sorted ? value_type'(u[31:0]) ^ SIGN_BIT : value_type'($urandom);
         if ($urandom_range(9, 0) != 0) y = $urandom;
         send_request(clin_pkg::FUNC_LOAD, index_type'(i), x, y, $urandom);
      end
   endtask

   function automatic value_type pick_query();
      int      n;
      int      k;
      longint  u;
      n = sb.active_count();
      k = $urandom_range(n - 1, 0);
      case ($urandom_range(9, 0))
         0: u = longint'($urandom);
         1: u = longint'(sb.knot_x[0] ^ SIGN_BIT) - $urandom_range(3, 0);
         2: u = longint'(sb.knot_x[n - 1] ^ SIGN_BIT) + $urandom_range(3, 0);
         3, 4: u = longint'(sb.knot_x[k] ^ SIGN_BIT) + $urandom_range(2, 0) - 1;
         default: begin
            if (n < 2) begin
               u = longint'($urandom);
            end else begin
               k = $urandom_range(n - 2, 0);
               u = longint'($urandom_range(sb.knot_x[k] ^ SIGN_BIT,
                                           sb.knot_x[k + 1] ^ SIGN_BIT));
            end
         end
      endcase
      if (u < 0) u = 0;
      if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
      return value_type'(u[31:0]) ^ SIGN_BIT;
   endfunction

   task automatic run_queries(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9, 0) == 0)
            send_request(clin_pkg::FUNC_LOAD, index_type'($urandom), $urandom, $urandom,
                         $urandom);
         else
            send_request(clin_pkg::FUNC_QUERY, index_type'($urandom), $urandom, $urandom,
                         pick_query());
      end
   endtask

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int        n;
      count_type c;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme knots with falling, rising and flat segments
      send_request(clin_pkg::FUNC_LOAD, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, '0);
      send_request(clin_pkg::FUNC_LOAD, 8'd1, 32'hFFFF_0000, 32'h8000_0000, '0);
      send_request(clin_pkg::FUNC_LOAD, 8'd2, 32'h0001_0000, 32'h0001_0000, '0);
      send_request(clin_pkg::FUNC_LOAD, 8'd3, 32'h7FFF_FFFF, 32'h0001_0000, '0);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h8000_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h0000_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h7FFF_FFFF);
      write_point_count(count_type'(4));
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h8000_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h8000_0001);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'hFFFF_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'hFFFF_FFFF);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h0000_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h0000_8000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h0001_0000);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h0001_0001);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h7FFF_FFFF);
      write_point_count(count_type'(0));
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h7FFF_FFFF);
      send_request(clin_pkg::FUNC_QUERY, '0, '0, '0, 32'h8000_0000);

      // full table, then oversized count
      load_table(DEPTH, 1'b1);
      write_point_count('1);
      run_queries(12);

      while (items < ITEM_TARGET) begin
         case ($urandom_range(19, 0))
            0: c = '0;
            1: c = count_type'($urandom_range(511, DEPTH + 1));
            2: c = count_type'(DEPTH);
            3, 4, 5: c = count_type'($urandom_range(DEPTH - 1, 17));
            default: c = count_type'($urandom_range(16, 1));
         endcase
         idle_on = 1'b0;
         write_point_count(c);
         n = sb.active_count();
         idle_on = ($urandom_range(3, 0) != 0);
         if (n <= 16 ? $urandom_range(4, 0) != 0 : $urandom_range(3, 0) == 0)
            load_table(n, $urandom_range(9, 0) != 0);
         run_queries($urandom_range(40, 8));
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d knot loads, %0d queries, %0d count settings",
               items, sb.loads, sb.queries, sb.settings);
      $display("summary: %0d interpolated, %0d clamped low, %0d clamped high",
               sb.region_hits[clin_pkg::REGION_INSIDE], sb.region_hits[clin_pkg::REGION_FIRST],
               sb.region_hits[clin_pkg::REGION_LAST]);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
